>>> hdl/bf5_pkg.sv
// Shared types and constants for the 5x5 RGB box filter.
package bf5_pkg;

	// Pixel and window geometry
	localparam int PIX_W    = 8;
	localparam int WIN      = 5;
	localparam int LINES    = WIN - 1;
	localparam int COLSUM_W = 11;  // five 8-bit values
	localparam int SUM_W    = 13;  // twenty-five 8-bit values

	// floor(x / 25) == (x * 5243) >> 17 for every x up to 25 * 255
	localparam int RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
	localparam int RECIP_SHIFT = 17;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int ROW_W      = 17;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} pix_t;

	// One column of the four line stores, index 0 is the oldest row
	typedef pix_t [LINES-1:0] line_t;

	typedef logic [SUM_W-1:0] sum_t;

	// Stage advance strobes for the window/sum datapath
	typedef struct packed {
		logic win_shift;  // new column enters the window
		logic sum_load;   // window total is registered
	} bf5_adv_t;

endpackage

>>> hdl/bf5_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bf5_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1028
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/bf5_window.sv
// Sliding 5x5 window kept as five column sums per channel, plus window total.
module bf5_window (
	input  logic                  clk,
	input  bf5_pkg::bf5_adv_t     adv,
	input  bf5_pkg::line_t        lines,
	input  bf5_pkg::pix_t         pix,
	output bf5_pkg::sum_t         red_sum_s3,
	output bf5_pkg::sum_t         green_sum_s3,
	output bf5_pkg::sum_t         blue_sum_s3
);
	import bf5_pkg::*;

	logic [COLSUM_W-1:0] r_col_q [WIN];
	logic [COLSUM_W-1:0] g_col_q [WIN];
	logic [COLSUM_W-1:0] b_col_q [WIN];
	logic [COLSUM_W-1:0] r_new, g_new, b_new;
	sum_t                r_tot, g_tot, b_tot;

	// sum of the incoming column: four stored rows and the new pixel
	always_comb begin
		r_new = COLSUM_W'(pix.r);
		g_new = COLSUM_W'(pix.g);
		b_new = COLSUM_W'(pix.b);
		for (int k = 0; k < LINES; k++) begin
			r_new = r_new + COLSUM_W'(lines[k].r);
			g_new = g_new + COLSUM_W'(lines[k].g);
			b_new = b_new + COLSUM_W'(lines[k].b);
		end
	end

	// shift the window left by one column
	always_ff @(posedge clk) begin
		if (adv.win_shift) begin
			for (int j = 0; j < WIN - 1; j++) begin
				r_col_q[j] <= r_col_q[j+1];
				g_col_q[j] <= g_col_q[j+1];
				b_col_q[j] <= b_col_q[j+1];
			end
			r_col_q[WIN-1] <= r_new;
			g_col_q[WIN-1] <= g_new;
			b_col_q[WIN-1] <= b_new;
		end
	end

	// window total over the five column sums
	always_comb begin
		r_tot = '0;
		g_tot = '0;
		b_tot = '0;
		for (int j = 0; j < WIN; j++) begin
			r_tot = r_tot + SUM_W'(r_col_q[j]);
			g_tot = g_tot + SUM_W'(g_col_q[j]);
			b_tot = b_tot + SUM_W'(b_col_q[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.sum_load) begin
			red_sum_s3   <= r_tot;
			green_sum_s3 <= g_tot;
			blue_sum_s3  <= b_tot;
		end
	end

endmodule

>>> hdl/bf5_mean.sv
// Divide the three window totals by 25 with a reciprocal multiply.
module bf5_mean (
	input  logic                           clk,
	input  logic                           load,
	input  bf5_pkg::sum_t                  red_sum,
	input  bf5_pkg::sum_t                  green_sum,
	input  bf5_pkg::sum_t                  blue_sum,
	output logic [bf5_pkg::PIX_W-1:0]      red_mean_q,
	output logic [bf5_pkg::PIX_W-1:0]      green_mean_q,
	output logic [bf5_pkg::PIX_W-1:0]      blue_mean_q
);
	import bf5_pkg::*;

	localparam int PROD_W = SUM_W + RECIP_W;

	logic [PROD_W-1:0] r_prod, g_prod, b_prod;

	assign r_prod = PROD_W'(red_sum) * PROD_W'(RECIP);
	assign g_prod = PROD_W'(green_sum) * PROD_W'(RECIP);
	assign b_prod = PROD_W'(blue_sum) * PROD_W'(RECIP);

	// quotient sits above the reciprocal's fraction bits
	always_ff @(posedge clk) begin
		if (load) begin
			red_mean_q   <= r_prod[RECIP_SHIFT +: PIX_W];
			green_mean_q <= g_prod[RECIP_SHIFT +: PIX_W];
			blue_mean_q  <= b_prod[RECIP_SHIFT +: PIX_W];
		end
	end

endmodule

>>> hdl/box_filter_5x5_rgb_core.sv
// Top level of the streaming 5x5 RGB box filter.
//
// Usage: send the padded frame (two zero pixels on every side) in raster
// order on the in_ channel, one pixel per request. One result per unpadded
// pixel leaves on the out_ channel in raster order; frame_end marks the last
// result of the frame. The cfg_ channel writes image_width (index 0) and
// image_height (index 1); cfg_ready is always high; the user must write only
// while idle, which the block does not enforce. A result passes the s1, s2,
// s3 and mean registers after the pixel that completes its window is
// accepted. Throughput: one pixel per cycle; the line store is a single RAM
// holding all four rows of a column, read at acceptance and written back as
// the pixel leaves s1, which sets that rate. Reset: counters return to the
// frame start, registers to 1024x1024, and a clearing pass writes zero to
// all MAX_WIDTH+4 line-store columns, one per cycle, while in_ready is low.
// Stall: each stage advances when the one after it is empty or moving, so
// bubbles fill while out_valid waits; a full pipeline drops in_ready.
module box_filter_5x5_rgb_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bf5_pkg::PIX_W-1:0]         red,
	input  logic [bf5_pkg::PIX_W-1:0]         green,
	input  logic [bf5_pkg::PIX_W-1:0]         blue,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bf5_pkg::PIX_W-1:0]         red_mean,
	output logic [bf5_pkg::PIX_W-1:0]         green_mean,
	output logic [bf5_pkg::PIX_W-1:0]         blue_mean,
	output logic                              frame_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bf5_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bf5_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bf5_pkg::*;

	localparam int RAM_DEPTH = MAX_WIDTH + WIN - 1;
	localparam int COL_W     = $clog2(RAM_DEPTH);
	localparam int EXT_W     = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;
	localparam int LINE_W    = $bits(line_t);

	// configuration registers
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;

	// position counters and clearing pass
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             clr_q;
	logic [COL_W-1:0] clr_addr_q;

	// pipeline control
	logic             v1_s1, v2_s2, v3_s3, out_valid_q;
	logic             emit_s1, last_s1, last_s2, last_s3, frame_end_q;
	logic [COL_W-1:0] addr_s1;
	pix_t             pix_s1;

	logic             en1, en2, en3, en_out, in_acc;
	logic [EXT_W-1:0] width_ext;
	logic [COL_W-1:0] eff_width, last_col;
	logic [ROW_W-1:0] eff_height, last_row;
	logic             col_wrap, row_wrap;

	logic             ram_we;
	logic [COL_W-1:0] ram_waddr;
	line_t            ram_wdata, ram_rdata;
	bf5_adv_t         adv;
	sum_t             red_sum_s3, green_sum_s3, blue_sum_s3;

	// configuration writes, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data[WIDTH_W-1:0];
			end else if (cfg_index == REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[HEIGHT_W-1:0];
			end
		end
	end

	// effective frame size: zero acts as one, width saturates at MAX_WIDTH
	assign width_ext = EXT_W'(width_q);

	always_comb begin
		priority if (width_q == '0) begin
			eff_width = COL_W'(1);
		end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
			eff_width = COL_W'(MAX_WIDTH);
		end else begin
			eff_width = COL_W'(width_ext);
		end
	end

	assign eff_height = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
	assign last_col   = eff_width + COL_W'(WIN - 2);
	assign last_row   = eff_height + ROW_W'(WIN - 2);
	assign col_wrap   = col_q >= last_col;
	assign row_wrap   = row_q >= last_row;

	// stage enables: a stage moves when the next one is empty or moving
	assign en_out   = !out_valid_q || out_ready;
	assign en3      = !v3_s3 || en_out;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1 && !clr_q;
	assign in_acc   = in_valid && in_ready;

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line-store clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + COL_W'(1);
			if (clr_addr_q == COL_W'(RAM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_s1 <= in_acc;
			end
			if (en2) begin
				v2_s2 <= v1_s1 && emit_s1;
			end
			if (en3) begin
				v3_s3 <= v2_s2;
			end
			if (en_out) begin
				out_valid_q <= v3_s3;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= '{r: red, g: green, b: blue};
			addr_s1 <= col_q;
			emit_s1 <= (row_q >= ROW_W'(WIN - 1)) && (col_q >= COL_W'(WIN - 1));
			last_s1 <= row_wrap && col_wrap;
		end
		if (en2 && v1_s1) begin
			last_s2 <= last_s1;
		end
		if (en3 && v2_s2) begin
			last_s3 <= last_s2;
		end
		if (en_out && v3_s3) begin
			frame_end_q <= last_s3;
		end
	end

	// line store: read the column at acceptance, write it back shifted a row
	assign ram_we    = clr_q || (v1_s1 && en2);
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? line_t'('0) : {pix_s1, ram_rdata[LINES-1:1]};

	bf5_ram #(
		.WIDTH (LINE_W),
		.DEPTH (RAM_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign adv.win_shift = v1_s1 && en2;
	assign adv.sum_load  = v2_s2 && en3;

	bf5_window u_window (
		.clk          (clk),
		.adv          (adv),
		.lines        (ram_rdata),
		.pix          (pix_s1),
		.red_sum_s3   (red_sum_s3),
		.green_sum_s3 (green_sum_s3),
		.blue_sum_s3  (blue_sum_s3)
	);

	bf5_mean u_mean (
		.clk          (clk),
		.load         (v3_s3 && en_out),
		.red_sum      (red_sum_s3),
		.green_sum    (green_sum_s3),
		.blue_sum     (blue_sum_s3),
		.red_mean_q   (red_mean),
		.green_mean_q (green_mean),
		.blue_mean_q  (blue_mean)
	);

	assign out_valid = out_valid_q;
	assign frame_end = frame_end_q;

	// no request is taken while the line store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready)
		else $error("request accepted during line-store clear");

	// write-back never lands on the column being read in the same cycle
	a_no_rmw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && v1_s1 && en2) |-> (addr_s1 != col_q))
		else $error("line-store read and write-back hit the same column");

	// a request at the last padded column wraps the column counter
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && col_wrap) |=> (col_q == '0))
		else $error("column counter did not wrap");

endmodule
